[hw/rtl/clac_pkg.sv]
// Shared types and constants for the clipped autocorrelation block.
// Used by clac_ctrl, clac_dp and clipped_autocorrelation; no other dependencies.
package clac_pkg;

  localparam int MAX_WINDOW  = 2048;
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int MAG_W       = SAMPLE_BITS + 1;
  localparam int CMP_W       = SAMPLE_BITS + 4;
  localparam int CORR_W      = 13;
  localparam int CFG_W       = 12;
  localparam int OUT_W       = ADDR_W + CORR_W;

  localparam logic [CFG_W-1:0] WL_RESET = CFG_W'(512);
  localparam logic [CNT_W-1:0] WL_MIN   = CNT_W'(4);
  localparam logic [CNT_W-1:0] WL_MAX   = CNT_W'(MAX_WINDOW);

  // Reciprocal of three, 17 fractional bits, exact for dividends up to 2*MAX_WINDOW
  localparam int               RECIP3_SH = 17;
  localparam logic [RECIP3_SH-1:0] RECIP3 = RECIP3_SH'(43691);

  // Three-level clip codes
  localparam logic [1:0] CLIP_ZERO = 2'b00;
  localparam logic [1:0] CLIP_POS  = 2'b01;
  localparam logic [1:0] CLIP_NEG  = 2'b11;

  // Commands from controller to datapath
  typedef struct packed {
    logic                   smp_we;
    logic [ADDR_W-1:0]      smp_wa;
    logic [SAMPLE_BITS-1:0] smp_wd;
    logic                   smp_re;
    logic [ADDR_W-1:0]      smp_ra;
    logic                   rd_peak;
    logic                   rd_clip;
    logic                   in_a;
    logic                   in_b;
    logic                   zero;
    logic                   pk_clear;
    logic                   pk_min;
    logic                   cr_re;
    logic [ADDR_W-1:0]      cr_ra;
    logic [ADDR_W-1:0]      cr_rb;
    logic                   cr_first;
    logic                   cr_last;
    logic [ADDR_W-1:0]      cr_lag;
    logic                   res_re;
    logic [ADDR_W-1:0]      res_ra;
    logic                   out_load;
    logic                   out_hit;
    logic [ADDR_W-1:0]      out_lag;
    logic                   out_last;
  } cmd_t;

endpackage

[hw/rtl/clac_dp.sv]
// Datapath: sample, clip and result memories, peak search, clipping,
// correlation accumulator and output register. Depends on clac_pkg.
module clac_dp (
  input  logic                                   clk,
  input  clac_pkg::cmd_t                         cmd,
  output logic [clac_pkg::OUT_W-1:0]             m_tdata,   // lag [10:0], correlation [23:11]
  output logic                                   m_tlast,
  output logic                                   m_tuser    // no_data
);

  logic signed [clac_pkg::SAMPLE_BITS-1:0] smp_mem [clac_pkg::MAX_WINDOW];
  logic [1:0]                              clip_mem [clac_pkg::MAX_WINDOW];
  logic [clac_pkg::CORR_W-1:0]             res_mem [clac_pkg::MAX_WINDOW];

  logic signed [clac_pkg::SAMPLE_BITS-1:0] smp_q;
  logic [1:0]                              ca_q, cb_q;
  logic [clac_pkg::CORR_W-1:0]             res_q;

  // delayed command flags, aligned with memory read data
  logic                        peak_v, clip_v, a_d, b_d, zero_d, cr_v, first_d, last_d;
  logic [clac_pkg::ADDR_W-1:0] idx_d, lag_d;

  logic [clac_pkg::MAG_W-1:0]  peak_a, peak_b;
  logic [clac_pkg::CMP_W-1:0]  peak3;
  logic signed [clac_pkg::CORR_W-1:0] acc;

  logic signed [clac_pkg::CMP_W-1:0] x_ext, x5, p3;
  logic [clac_pkg::MAG_W-1:0]  mag, pk_lo;
  logic [1:0]                  clip_val;
  logic signed [clac_pkg::CORR_W-1:0] prod, acc_sum;

  // sample memory
  always_ff @(posedge clk) begin
    if (cmd.smp_we) smp_mem[cmd.smp_wa] <= cmd.smp_wd;
    if (cmd.smp_re) smp_q <= smp_mem[cmd.smp_ra];
  end

  // clip memory, two read ports for the pair
  always_ff @(posedge clk) begin
    if (clip_v) clip_mem[idx_d] <= clip_val;
    if (cmd.cr_re) begin
      ca_q <= clip_mem[cmd.cr_ra];
      cb_q <= clip_mem[cmd.cr_rb];
    end
  end

  // result memory
  always_ff @(posedge clk) begin
    if (cr_v && last_d) res_mem[lag_d] <= acc_sum;
    if (cmd.res_re) res_q <= res_mem[cmd.res_ra];
  end

  // pipeline alignment
  always_ff @(posedge clk) begin
    peak_v  <= cmd.smp_re & cmd.rd_peak;
    clip_v  <= cmd.smp_re & cmd.rd_clip;
    a_d     <= cmd.in_a;
    b_d     <= cmd.in_b;
    zero_d  <= cmd.zero;
    idx_d   <= cmd.smp_ra;
    cr_v    <= cmd.cr_re;
    first_d <= cmd.cr_first;
    last_d  <= cmd.cr_last;
    lag_d   <= cmd.cr_lag;
  end

  // sample as seen by the analysis: zero beyond the filled part
  always_comb begin
    x_ext = zero_d ? '0 : clac_pkg::CMP_W'(smp_q);
    mag   = x_ext[clac_pkg::CMP_W-1] ? clac_pkg::MAG_W'(-x_ext) : clac_pkg::MAG_W'(x_ext);
    x5    = (x_ext <<< 2) + x_ext;
    p3    = peak3;
    pk_lo = (peak_a < peak_b) ? peak_a : peak_b;
    if (x5 > p3)       clip_val = clac_pkg::CLIP_POS;
    else if (x5 < -p3) clip_val = clac_pkg::CLIP_NEG;
    else               clip_val = clac_pkg::CLIP_ZERO;
  end

  // peak tracking and clip threshold
  always_ff @(posedge clk) begin
    if (cmd.pk_clear) begin
      peak_a <= '0;
      peak_b <= '0;
    end else if (peak_v) begin
      if (a_d && mag > peak_a) peak_a <= mag;
      if (b_d && mag > peak_b) peak_b <= mag;
    end
    if (cmd.pk_min) peak3 <= (clac_pkg::CMP_W'(pk_lo) << 1) + clac_pkg::CMP_W'(pk_lo);
  end

  // pair product: zero if either is zero, +1 on agreement, -1 otherwise
  always_comb begin
    if (ca_q == clac_pkg::CLIP_ZERO || cb_q == clac_pkg::CLIP_ZERO) prod = '0;
    else if (ca_q == cb_q) prod = clac_pkg::CORR_W'(1);
    else                   prod = -clac_pkg::CORR_W'(1);
    acc_sum = (first_d ? '0 : acc) + prod;
  end

  always_ff @(posedge clk) begin
    if (cr_v) acc <= acc_sum;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= cmd.out_hit ? {res_q, cmd.out_lag} : '0;
      m_tlast <= cmd.out_hit & cmd.out_last;
      m_tuser <= ~cmd.out_hit;
    end
  end

endmodule

[hw/rtl/clac_ctrl.sv]
// Controller: window fill, analysis sequencing, fetch bookkeeping and
// handshakes. Depends on clac_pkg; drives clac_dp through cmd_t.
module clac_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [clac_pkg::SAMPLE_BITS-1:0]  s_tdata,
  input  logic                              s_tlast,
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clac_pkg::CFG_W-1:0]        cfg_data,
  output clac_pkg::cmd_t                    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_FETCH    = 4'd1;
  localparam logic [3:0] ST_SETUP    = 4'd2;
  localparam logic [3:0] ST_PEAK     = 4'd3;
  localparam logic [3:0] ST_PEAK_W   = 4'd4;
  localparam logic [3:0] ST_PEAK_MIN = 4'd5;
  localparam logic [3:0] ST_CLIP     = 4'd6;
  localparam logic [3:0] ST_CLIP_W   = 4'd7;
  localparam logic [3:0] ST_CORR     = 4'd8;
  localparam logic [3:0] ST_CORR_W   = 4'd9;

  localparam int W = clac_pkg::CNT_W;
  localparam int PW = W + 1 + clac_pkg::RECIP3_SH;

  logic [3:0]                 state, state_next;
  logic [clac_pkg::CFG_W-1:0] wl, wl_next;
  logic [W-1:0] fill, fill_next, nlen, nlen_next, alen, alen_next, rp, rp_next;
  logic [W-1:0] idx, idx_next, lag, lag_next, half, half_next, third, third_next;
  logic         ready, ready_next, m_tvalid_next;
  logic         f_hit, f_hit_next, f_last, f_last_next;
  logic [clac_pkg::ADDR_W-1:0] f_lag, f_lag_next;

  logic [W-1:0]  wl_eff, fill_inc, nlen_m1, jl;
  logic [PW-1:0] third_prod;

  always_comb begin
    if (clac_pkg::CNT_W'(wl) < clac_pkg::WL_MIN)      wl_eff = clac_pkg::WL_MIN;
    else if (clac_pkg::CNT_W'(wl) > clac_pkg::WL_MAX) wl_eff = clac_pkg::WL_MAX;
    else                                              wl_eff = clac_pkg::CNT_W'(wl);
    nlen_m1    = nlen - W'(1);
    jl         = idx + lag;
    third_prod = PW'({nlen, 1'b0}) * PW'(clac_pkg::RECIP3);
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // next-state and command logic
  always_comb begin
    state_next    = state;
    wl_next       = wl;
    fill_next     = fill;
    nlen_next     = nlen;
    alen_next     = alen;
    rp_next       = rp;
    idx_next      = idx;
    lag_next      = lag;
    half_next     = half;
    third_next    = third;
    ready_next    = ready;
    f_hit_next    = f_hit;
    f_last_next   = f_last;
    f_lag_next    = f_lag;
    m_tvalid_next = m_tvalid & ~m_tready;
    fill_inc      = fill;
    cmd           = '0;
    cmd.smp_wa    = fill[clac_pkg::ADDR_W-1:0];
    cmd.smp_wd    = s_tdata;
    cmd.smp_ra    = idx[clac_pkg::ADDR_W-1:0];
    cmd.cr_ra     = idx[clac_pkg::ADDR_W-1:0];
    cmd.cr_rb     = jl[clac_pkg::ADDR_W-1:0];
    cmd.cr_lag    = lag[clac_pkg::ADDR_W-1:0];
    cmd.res_ra    = rp[clac_pkg::ADDR_W-1:0];
    cmd.out_hit   = f_hit;
    cmd.out_lag   = f_lag;
    cmd.out_last  = f_last;

    if (cfg_valid) wl_next = cfg_data;

    case (state)
      ST_IDLE: begin
        if (s_tvalid && !s_tuser) begin
          // sample item
          if (!fill[W-1]) begin
            cmd.smp_we = 1'b1;
            fill_inc   = fill + W'(1);
          end
          fill_next = fill_inc;
          if (fill_inc >= wl_eff || s_tlast) begin
            fill_next  = (fill_inc > wl_eff) ? wl_eff : fill_inc;
            nlen_next  = wl_eff;
            state_next = ST_SETUP;
          end
        end else if (s_tvalid) begin
          // fetch item
          f_hit_next  = ready && (rp < alen);
          f_lag_next  = rp[clac_pkg::ADDR_W-1:0];
          f_last_next = (rp + W'(1) == alen);
          if (ready && rp < alen) begin
            cmd.res_re = 1'b1;
            rp_next    = rp + W'(1);
          end
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd.pk_clear = 1'b1;
        half_next    = nlen >> 1;
        third_next   = W'(third_prod >> clac_pkg::RECIP3_SH);
        idx_next     = '0;
        state_next   = ST_PEAK;
      end
      ST_PEAK: begin
        cmd.smp_re  = 1'b1;
        cmd.rd_peak = 1'b1;
        cmd.in_a    = idx < half;
        cmd.in_b    = idx >= third;
        cmd.zero    = idx >= fill;
        if (idx == nlen_m1) state_next = ST_PEAK_W;
        else                idx_next   = idx + W'(1);
      end
      ST_PEAK_W:   state_next = ST_PEAK_MIN;
      ST_PEAK_MIN: begin
        cmd.pk_min = 1'b1;
        idx_next   = '0;
        state_next = ST_CLIP;
      end
      ST_CLIP: begin
        cmd.smp_re  = 1'b1;
        cmd.rd_clip = 1'b1;
        cmd.zero    = idx >= fill;
        if (idx == nlen_m1) state_next = ST_CLIP_W;
        else                idx_next   = idx + W'(1);
      end
      ST_CLIP_W: begin
        idx_next   = '0;
        lag_next   = '0;
        state_next = ST_CORR;
      end
      ST_CORR: begin
        cmd.cr_re    = 1'b1;
        cmd.cr_first = (idx == '0);
        cmd.cr_last  = (jl == nlen_m1);
        if (jl == nlen_m1) begin
          idx_next = '0;
          if (lag == nlen_m1) state_next = ST_CORR_W;
          else                lag_next   = lag + W'(1);
        end else begin
          idx_next = idx + W'(1);
        end
      end
      ST_CORR_W: begin
        ready_next = 1'b1;
        rp_next    = '0;
        fill_next  = '0;
        alen_next  = nlen;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wl       <= clac_pkg::WL_RESET;
      fill     <= '0;
      alen     <= '0;
      rp       <= '0;
      ready    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      wl       <= wl_next;
      fill     <= fill_next;
      alen     <= alen_next;
      rp       <= rp_next;
      ready    <= ready_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    nlen   <= nlen_next;
    idx    <= idx_next;
    lag    <= lag_next;
    half   <= half_next;
    third  <= third_next;
    f_hit  <= f_hit_next;
    f_last <= f_last_next;
    f_lag  <= f_lag_next;
  end

endmodule

[hw/rtl/clipped_autocorrelation.sv]
// Clipped autocorrelation top level. A sample item is taken in ST_IDLE; a fetch item
// goes via ST_FETCH to the output register, which stalls only on a full output slot.
// A window of n samples is analysed in peak, clip and correlation passes, the last a
// one-pair-per-cycle loop over the clip memory; no item is taken then.
// Reset (rst, synchronous): empty window, no results, window_length = 512;
// memories are not cleared.
module clipped_autocorrelation (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [clac_pkg::SAMPLE_BITS-1:0] s_tdata,   // sample [15:0]
  input  logic                             s_tlast,   // stream_end
  input  logic                             s_tuser,   // mode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [clac_pkg::OUT_W-1:0]       m_tdata,   // lag [10:0], correlation [23:11]
  output logic                             m_tlast,   // last_lag
  output logic                             m_tuser,   // no_data
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [clac_pkg::CFG_W-1:0]       cfg_data   // window_length
);

  clac_pkg::cmd_t cmd;

  clac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd)
  );

  clac_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

[tb/tb.sv]
// Testbench for clipped_autocorrelation: directed and random sample/fetch items with
// a self-contained predictor of the clipped correlation. Depends on clac_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [10:0]        lag;
    logic signed [12:0] corr;
    logic               last;
    logic               nodata;
  } lag_res_t;

  // Correlation predictor and store of expected lag results
  class lag_scoreboard;
    logic signed [15:0] win_smp[clac_pkg::MAX_WINDOW];
    int                 win_clip[clac_pkg::MAX_WINDOW];
    int                 win_corr[clac_pkg::MAX_WINDOW];
    int                 fill;
    int                 rd_ptr;
    int                 done_len;
    bit                 have_win;
    int                 wlen;
    int                 errors;
    lag_res_t           pend_q[$];

    function new();
      fill = 0;
      rd_ptr = 0;
      done_len = 0;
      have_win = 0;
      wlen = 512;
      errors = 0;
    endfunction

    function void set_length(int v);
      wlen = v;
    endfunction

    function int pending();
      return pend_q.size();
    endfunction

    // Zero-fill, clip against 0.6 of the smaller peak, correlate every lag
    function void analyse(int n);
      int pk_a, pk_b, pk, mag, acc, x5;
      pk_a = 0;
      pk_b = 0;
      for (int i = fill; i < n; i++) win_smp[i] = '0;
      for (int i = 0; i < n / 2; i++) begin
        mag = win_smp[i] < 0 ? -int'(win_smp[i]) : int'(win_smp[i]);
        if (mag > pk_a) pk_a = mag;
      end
      for (int i = (2 * n) / 3; i < n; i++) begin
        mag = win_smp[i] < 0 ? -int'(win_smp[i]) : int'(win_smp[i]);
        if (mag > pk_b) pk_b = mag;
      end
      pk = pk_a < pk_b ? pk_a : pk_b;
      for (int i = 0; i < n; i++) begin
        x5 = 5 * int'(win_smp[i]);
        if (x5 > 3 * pk) win_clip[i] = 1;
        else if (x5 < -3 * pk) win_clip[i] = -1;
        else win_clip[i] = 0;
      end
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j + i < n; j++) acc += win_clip[j] * win_clip[j + i];
        win_corr[i] = acc;
      end
      done_len = n;
      have_win = 1;
      rd_ptr = 0;
      fill = 0;
    endfunction

    // Note an accepted input item
    function void note_input(bit fetch, logic [15:0] smp, bit s_end);
      int       n;
      lag_res_t r;
      if (!fetch) begin
        n = wlen < 4 ? 4 : (wlen > clac_pkg::MAX_WINDOW ? clac_pkg::MAX_WINDOW : wlen);
        if (fill < clac_pkg::MAX_WINDOW) begin
          win_smp[fill] = smp;
          fill++;
        end
        if (fill >= n || s_end) begin
          if (fill > n) fill = n;
          analyse(n);
        end
      end else if (!have_win || rd_ptr >= done_len) begin
        r = '{lag: '0, corr: '0, last: 1'b0, nodata: 1'b1};
        pend_q.push_back(r);
      end else begin
        r.lag = rd_ptr[10:0];
        r.corr = 13'(win_corr[rd_ptr]);
        r.last = (rd_ptr + 1 == done_len);
        r.nodata = 1'b0;
        pend_q.push_back(r);
        rd_ptr++;
      end
    endfunction

    // Compare one output item with the oldest expectation
    function void check(logic [10:0] lag, logic [12:0] corr, logic last, logic nodata);
      lag_res_t e;
      if (pend_q.size() == 0) begin
        $error("unexpected output item lag=%0d", lag);
        errors++;
        return;
      end
      e = pend_q.pop_front();
      if (lag !== e.lag) begin
        $error("lag: expected %0d, got %0d", e.lag, lag);
        errors++;
      end
      if (corr !== e.corr) begin
        $error("correlation: expected %0d, got %0d", e.corr, $signed(corr));
        errors++;
      end
      if (last !== e.last) begin
        $error("last_lag: expected %0b, got %0b", e.last, last);
        errors++;
      end
      if (nodata !== e.nodata) begin
        $error("no_data: expected %0b, got %0b", e.nodata, nodata);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 400000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [clac_pkg::SAMPLE_BITS-1:0] s_tdata = '0;
  logic                             s_tlast = 1'b0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [clac_pkg::OUT_W-1:0]       m_tdata;
  logic                             m_tlast;
  logic                             m_tuser;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [clac_pkg::CFG_W-1:0]       cfg_data = '0;

  lag_scoreboard sb = new();
  int src_idle = 34;
  int dst_idle = 50;
  int hold_cycles = 0;
  int quiet = 0;

  clipped_autocorrelation u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: check accepted items, random back-pressure, long hold on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready)
      sb.check(m_tdata[10:0], m_tdata[23:11], m_tlast, m_tuser);
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(bit fetch, logic [15:0] smp, bit s_end);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fetch;
    s_tdata <= smp;
    s_tlast <= s_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(fetch, smp, s_end);
  endtask

  task automatic write_length(int v);
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_data <= clac_pkg::CFG_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_length(v);
  endtask

  // Wait until every expected item has come back, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'(int'($urandom_range(200)) - 100);
  endfunction

  // Random mix of samples, fetches and early stream ends under one window length
  task automatic random_phase(int len, int count);
    bit fetch;
    write_length(len);
    for (int i = 0; i < count; i++) begin
      fetch = ($urandom_range(99) < 35);
      send_item(fetch, rand_sample(), !fetch && ($urandom_range(99) < 4) ? 1'b1
                                                                         : 1'b0);
    end
    send_item(1'b1, 16'($urandom), 1'b0);
    drain();
  endtask

  int lens[10] = '{0, 5, 16, 37, 64, 9, 23, 48, 3, 30};

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fetch with no window, extremes at default length, early end
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 16'h7fff, 1'b0);
    send_item(1'b0, 16'h8000, 1'b0);
    send_item(1'b0, 16'h0000, 1'b0);
    send_item(1'b0, 16'h0001, 1'b0);
    send_item(1'b0, 16'hffff, 1'b0);
    send_item(1'b0, 16'h5555, 1'b1);
    repeat (3) send_item(1'b1, 16'haaaa, 1'b1);
    drain();

    // Shortest window, read past the end
    write_length(4);
    send_item(1'b0, 16'h0100, 1'b0);
    send_item(1'b0, 16'hff00, 1'b0);
    send_item(1'b0, 16'h0010, 1'b0);
    send_item(1'b0, 16'h0200, 1'b0);
    repeat (6) send_item(1'b1, 16'h0000, 1'b0);
    drain();

    // Oversized register, then shrunk below the fill level
    write_length(4095);
    for (int i = 0; i < 10; i++) send_item(1'b0, rand_sample(), 1'b0);
    drain();
    write_length(7);
    send_item(1'b0, 16'h1234, 1'b0);
    repeat (8) send_item(1'b1, 16'h0000, 1'b0);
    drain();
    write_length(2048);
    for (int i = 0; i < 20; i++) send_item(1'b0, rand_sample(), 1'b0);
    drain();
    write_length(0);
    send_item(1'b0, 16'h8000, 1'b0);
    repeat (5) send_item(1'b1, 16'h0000, 1'b0);
    drain();

    // Random phases under changing idling
    for (int p = 0; p < 10; p++) begin
      if (p < 4) begin
        src_idle = 34;
        dst_idle = 50;
      end else if (p < 7) begin
        src_idle = 50;
        dst_idle = 34;
      end else begin
        src_idle = 0;
        dst_idle = 0;
      end
      if (p == 7) hold_cycles = 500;
      random_phase(lens[p], 190);
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/clac_pkg.sv
hw/rtl/clac_dp.sv
hw/rtl/clac_ctrl.sv
hw/rtl/clipped_autocorrelation.sv
tb/tb.sv
